// ----- src/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg: modular exponentiation types and microprogram
// Control word layout, opcodes, jump conditions and the read-only program
// that sequences the square-and-multiply datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int PC_W   = 3;
  localparam int MOD_W  = 31;
  localparam int BASE_W = 32;
  localparam int CNT_W  = 5;          // one multiply step per multiplier-word bit
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BASE_W - 1);

  // Datapath operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_REDUCE = 2'd1;  // b   = base_in mod m
  localparam logic [1:0] OP_MULRES = 2'd2;  // res = res * b mod m
  localparam logic [1:0] OP_SQUARE = 2'd3;  // b   = b * b mod m

  // Jump conditions
  localparam logic [2:0] CND_NEXT     = 3'd0;  // fall through
  localparam logic [2:0] CND_ALWAYS   = 3'd1;
  localparam logic [2:0] CND_NO_START = 3'd2;
  localparam logic [2:0] CND_EXP_ZERO = 3'd3;
  localparam logic [2:0] CND_BIT_CLR  = 3'd4;
  localparam logic [2:0] CND_REM_SET  = 3'd5;  // exponent bits above bit 0 remain

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_REDUCE = 3'd1;
  localparam logic [PC_W-1:0] PC_TEST   = 3'd2;
  localparam logic [PC_W-1:0] PC_BIT    = 3'd3;
  localparam logic [PC_W-1:0] PC_MULRES = 3'd4;
  localparam logic [PC_W-1:0] PC_SQUARE = 3'd5;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd6;

  typedef struct packed {
    logic [1:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic            shift;   // shift exponent right at end of step
    logic            finish;  // present the result
  } ctrl_word_t;

  function automatic ctrl_word_t micro_rom(input logic [PC_W-1:0] addr);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: CND_ALWAYS, target: PC_IDLE, shift: 1'b0, finish: 1'b0};
    unique case (addr)
      PC_IDLE:   w = '{op: OP_NONE,   cond: CND_NO_START, target: PC_IDLE,
                       shift: 1'b0, finish: 1'b0};
      PC_REDUCE: w = '{op: OP_REDUCE, cond: CND_NEXT,     target: PC_IDLE,
                       shift: 1'b0, finish: 1'b0};
      PC_TEST:   w = '{op: OP_NONE,   cond: CND_EXP_ZERO, target: PC_FINISH,
                       shift: 1'b0, finish: 1'b0};
      PC_BIT:    w = '{op: OP_NONE,   cond: CND_BIT_CLR,  target: PC_SQUARE,
                       shift: 1'b0, finish: 1'b0};
      PC_MULRES: w = '{op: OP_MULRES, cond: CND_NEXT,     target: PC_IDLE,
                       shift: 1'b0, finish: 1'b0};
      PC_SQUARE: w = '{op: OP_SQUARE, cond: CND_REM_SET,  target: PC_BIT,
                       shift: 1'b1, finish: 1'b0};
      PC_FINISH: w = '{op: OP_NONE,   cond: CND_ALWAYS,   target: PC_IDLE,
                       shift: 1'b0, finish: 1'b1};
      default:   w = '{op: OP_NONE,   cond: CND_ALWAYS,   target: PC_IDLE,
                       shift: 1'b0, finish: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- src/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus
// Right-to-left binary square-and-multiply driven by a small microprogram,
// with one shared shift-add modular multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                Handshake
//  --------  -------------------------------------  ------------------------------
//  command   start, base_value, exponent, busy      beat taken when start & !busy
//  result    done, power_result                     one-cycle strobe, no backpressure
//  config    cfg_we, cfg_data                       written when cfg_we is high
//
//  The strobe cycle is already idle, so a new beat can be taken while done
//  is high. The shared modular multiplier retires one multiplier-word bit
//  per cycle; the base reduction costs one multiplication and each exponent
//  bit costs a test step, an optional multiply into the result and a
//  squaring of the base. A zero exponent skips the bit steps after the reduction.
//  Reset loads the modulus with 1000000007 and returns the sequencer to idle.
//  busy is high from the cycle after the beat through the finish step and
//  drops in the strobe cycle; the receiver cannot stall, so done lasts
//  exactly one cycle.
//
module modular_exponentiation #(
  parameter int EXP_BITS = 62
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mexp_pkg::BASE_W-1:0] base_value,
  input  logic [EXP_BITS-1:0]         exponent,
  output logic                        done,
  output logic [mexp_pkg::MOD_W-1:0]  power_result,
  input  logic                        cfg_we,
  input  logic [mexp_pkg::MOD_W-1:0]  cfg_data
);

  import mexp_pkg::*;

  // Sequencer
  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  logic [CNT_W-1:0] mcnt;
  ctrl_word_t       cw;
  logic             step_end;
  logic             take;

  // Operands and results
  logic [MOD_W-1:0]    modulus;
  logic [MOD_W-1:0]    m;
  logic [BASE_W-1:0]   base_in;
  logic [EXP_BITS-1:0] exp_reg;
  logic [MOD_W-1:0]    b;
  logic [MOD_W-1:0]    res;
  logic [MOD_W-1:0]    acc;

  // Multiplier datapath
  logic [MOD_W-1:0]  mul_a;
  logic [BASE_W-1:0] mul_word;
  logic              mul_bit;
  logic [MOD_W-1:0]  acc_cur;
  logic [MOD_W+1:0]  sum;
  logic [MOD_W+1:0]  m1;
  logic [MOD_W+1:0]  m2;
  logic [MOD_W-1:0]  acc_next;

  assign cw   = micro_rom(pc);
  assign busy = (pc != PC_IDLE);

  // A multiply step holds until the bit counter reaches CNT_LAST; a step with no operation ends at once.
  assign step_end = (cw.op == OP_NONE) || (mcnt == CNT_LAST);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    unique case (cw.cond)
      CND_NEXT:     take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NO_START: take = !start;
      CND_EXP_ZERO: take = (exp_reg == '0);
      CND_BIT_CLR:  take = !exp_reg[0];
      CND_REM_SET:  take = (exp_reg[EXP_BITS-1:1] != '0);
      default:      take = 1'b1;
    endcase
    pc_next = take ? cw.target : pc + PC_W'(1);
  end

  // Select multiplicand and multiplier word for the active operation.
  always_comb begin
    case (cw.op)
      OP_REDUCE: begin
        mul_a    = MOD_W'(1);
        mul_word = base_in;
      end
      OP_MULRES: begin
        mul_a    = res;
        mul_word = {1'b0, b};
      end
      default: begin
        mul_a    = b;
        mul_word = {1'b0, b};
      end
    endcase
  end

  // One interleaved shift-add step: acc = (2*acc + bit*a) mod m.
  // Both acc and a stay at or below m, so the sum is below 3m and one of
  // two parallel subtractions brings it back in range.
  assign mul_bit = mul_word[CNT_LAST - mcnt];
  assign acc_cur = (mcnt == '0) ? '0 : acc;
  assign sum     = {1'b0, acc_cur, 1'b0} + (mul_bit ? {2'b00, mul_a} : '0);
  assign m1      = {2'b00, m};
  assign m2      = {1'b0, m, 1'b0};

  always_comb begin
    if (sum >= m2) begin
      acc_next = MOD_W'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = MOD_W'(sum - m1);
    end else begin
      acc_next = MOD_W'(sum);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= PC_IDLE;
      mcnt    <= '0;
      done    <= 1'b0;
      modulus <= MOD_W'(1000000007);
    end else begin
      done <= cw.finish;
      if (cfg_we) begin
        modulus <= cfg_data;
      end
      if (cw.op != OP_NONE) begin
        mcnt <= (mcnt == CNT_LAST) ? '0 : mcnt + CNT_W'(1);
      end
      if (step_end) begin
        pc <= pc_next;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pc == PC_IDLE && start) begin
      // capture the beat; a zero modulus acts as a modulus of one
      base_in <= base_value;
      exp_reg <= exponent;
      m       <= (modulus == '0) ? MOD_W'(1) : modulus;
      res     <= MOD_W'(1);
    end
    if (cw.op != OP_NONE) begin
      acc <= acc_next;
      if (mcnt == CNT_LAST) begin
        // retire the product into its destination
        if (cw.op == OP_MULRES) begin
          res <= acc_next;
        end else begin
          b <= acc_next;
        end
      end
    end
    if (cw.shift && step_end) begin
      exp_reg <= exp_reg >> 1;
    end
    if (cw.finish) begin
      power_result <= res;
    end
  end

endmodule
